>>> rtl/core/ppi_pkg.sv
package ppi_pkg;

    localparam int COORD_W          = 32;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int CNT_OUT_W        = 7;
    localparam int MAX_VERTICES_DEF = 64;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vertex;

    typedef struct packed {
        logic [1:0] cmd;
        t_coord     coord_x;
        t_coord     coord_y;
    } t_in_word;

    typedef struct packed {
        logic                 inside_res;
        logic [CNT_OUT_W-1:0] vertex_count;
        logic                 status;
    } t_out_word;

    function automatic t_diff sext(t_coord v);
        return t_diff'({v[COORD_W-1], v});
    endfunction

endpackage

>>> rtl/core/ppi_cell.sv
module ppi_cell
    import ppi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_vertex i_vtx,
    output t_vertex o_vtx
);

    t_vertex r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_vtx <= i_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

>>> rtl/core/ppi_edge.sv
module ppi_edge
    import ppi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_vertex i_start_prev,
    input  t_vertex i_start_pt,
    input  logic    i_valid,
    input  t_vertex i_cur,
    output logic    o_parity
);

    t_vertex r_prev;
    t_vertex r_pt;
    logic    r_v1;
    logic    r_v2;
    logic    r_st1;
    logic    r_st2;
    t_diff   r_a;
    t_diff   r_b;
    t_diff   r_c;
    t_diff   r_d;
    t_prod   r_p1;
    t_prod   r_p2;
    logic    r_parity;

    logic    w_cur_below;
    logic    w_prev_below;
    logic    w_prev_above;
    t_diff   w_a;
    t_diff   w_d;

    // The crossing x is left of the point when (py-cy)*(lx-cx) < (px-cx)*(ly-cy),
    // with both y differences taken positive.
    always_comb begin
        w_cur_below  = i_cur.y < r_pt.y;
        w_prev_below = r_prev.y < r_pt.y;
        w_prev_above = r_prev.y > i_cur.y;
        if (w_prev_above) begin
            w_a = sext(r_pt.y) - sext(i_cur.y);
            w_d = sext(r_prev.y) - sext(i_cur.y);
        end else begin
            w_a = sext(i_cur.y) - sext(r_pt.y);
            w_d = sext(i_cur.y) - sext(r_prev.y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            if (i_start) begin
                r_parity <= 1'b0;
            end else if (r_v2 && r_st2 && (r_p1 < r_p2)) begin
                r_parity <= !r_parity;
            end
        end
        if (i_start) begin
            r_prev <= i_start_prev;
            r_pt   <= i_start_pt;
        end else if (i_valid) begin
            r_prev <= i_cur;
        end
        r_st1 <= w_cur_below ^ w_prev_below;
        r_a   <= w_a;
        r_b   <= sext(r_prev.x) - sext(i_cur.x);
        r_c   <= sext(r_pt.x) - sext(i_cur.x);
        r_d   <= w_d;
        r_st2 <= r_st1;
        r_p1  <= t_prod'(r_a) * t_prod'(r_b);
        r_p2  <= t_prod'(r_c) * t_prod'(r_d);
    end

    assign o_parity = r_parity;

endmodule

>>> rtl/core/polygon_point_inclusion.sv
// Point-in-polygon block using the even-odd ray-casting rule.
// The input channel (i_in_valid, o_in_ready, i_in_word) takes one word per
// command: append a vertex, query a point, or clear the polygon. The output
// channel (o_out_valid, i_out_ready, o_out_word) returns exactly one word per
// command with the inside flag, the stored vertex count and the table-full flag.
// Vertices live in a ring of MAX_VERTICES cells. An append shifts the ring by one;
// the block then passes through its result state, which loads the word into the
// output register, and it can take the next command in the same cycle that word
// becomes valid. A query on a non-empty polygon rotates the whole ring once,
// feeding one edge per cycle into a three-stage cross-product unit, then drains
// that unit and passes through the result state in the same way. A query on an
// empty polygon, a clear and an unused command go through the result state like
// an append. One command is worked on at a time.
// The output register holds a finished word while the receiver stalls, and the
// next command is accepted meanwhile; its result waits until the register frees.
// Reset empties the polygon and the output register; cell contents are not reset.
module polygon_point_inclusion
    import ppi_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_step;
    logic [1:0]        r_drain;
    logic              r_res_inside;
    logic              r_res_status;
    logic              r_out_valid;
    t_out_word         r_out_word;

    t_vertex           w_cell_d [MAX_VERTICES];
    t_vertex           w_cell_q [MAX_VERTICES];
    t_vertex           w_new_vtx;
    t_vertex           w_tail;
    logic              w_accept;
    logic              w_not_full;
    logic              w_append;
    logic              w_shift;
    logic              w_start;
    logic              w_edge_valid;
    logic [CNT_W:0]    w_pos_sum;
    logic [EXT_W-1:0]  w_cnt_ext;
    logic              w_parity;

    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_not_full = r_count < CNT_W'(MAX_VERTICES);
    assign w_append   = w_accept && (i_in_word.cmd == CMD_APPEND) && w_not_full;
    assign w_start    = w_accept && (i_in_word.cmd == CMD_QUERY) && (r_count != '0);
    assign w_shift    = w_append || (r_state == S_SCAN);
    assign w_new_vtx  = '{x: i_in_word.coord_x, y: i_in_word.coord_y};
    assign w_tail     = w_cell_q[MAX_VERTICES-1];

    // After r_step rotations the tail shows cell MAX_VERTICES-1-r_step, which
    // holds a stored vertex when that index is below the count.
    assign w_pos_sum    = (CNT_W+1)'(r_step) + (CNT_W+1)'(r_count);
    assign w_edge_valid = (r_state == S_SCAN) && (w_pos_sum >= (CNT_W+1)'(MAX_VERTICES));
    assign w_cnt_ext    = EXT_W'(r_count);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_cell_d[gi] = (r_state == S_SCAN) ? w_tail : w_new_vtx;
            end else begin : g_body
                assign w_cell_d[gi] = w_cell_q[gi-1];
            end
            ppi_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_vtx   (w_cell_d[gi]),
                .o_vtx   (w_cell_q[gi])
            );
        end
    endgenerate

    ppi_edge u_edge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_start_prev (w_cell_q[0]),
        .i_start_pt   (w_new_vtx),
        .i_valid      (w_edge_valid),
        .i_cur        (w_tail),
        .o_parity     (w_parity)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res_inside <= 1'b0;
                        r_res_status <= 1'b0;
                        r_state      <= S_RESULT;
                        unique case (i_in_word.cmd)
                            CMD_APPEND: begin
                                if (w_not_full) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_res_status <= 1'b1;
                                end
                            end
                            CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_inside <= 1'b1;
                                end else begin
                                    r_step  <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == IDX_W'(MAX_VERTICES - 1)) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 2'd2) begin
                        r_res_inside <= w_parity;
                        r_state      <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid             <= 1'b1;
                        r_out_word.inside_res   <= r_res_inside;
                        r_out_word.vertex_count <= w_cnt_ext[CNT_OUT_W-1:0];
                        r_out_word.status       <= r_res_status;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
